[src/lnkm_pkg.sv]
package lnkm_pkg;

  // Default sizes of the block
  localparam int PATTERN_CHARS_DEFAULT = 8;
  localparam int MAX_BYTES_DEFAULT     = 255;

  // Fixed field widths
  localparam int CHAR_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 8;
  localparam int LEN_FIELD_W = 4;

  // Register reset values; pattern a is "gameim", first character in the low byte
  localparam logic [CFG_DATA_W-1:0]  PATTERN_A_TEXT_RESET   = 64'h0000_6D69_656D_6167;
  localparam logic [LEN_FIELD_W-1:0] PATTERN_A_LENGTH_RESET = 4'd6;
  localparam logic [CFG_DATA_W-1:0]  PATTERN_B_TEXT_RESET   = 64'h0;
  localparam logic [LEN_FIELD_W-1:0] PATTERN_B_LENGTH_RESET = 4'd0;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_A_TEXT   = 8'd0,
    REG_PATTERN_A_LENGTH = 8'd1,
    REG_PATTERN_B_TEXT   = 8'd2,
    REG_PATTERN_B_LENGTH = 8'd3
  } reg_index_t;

  // Control broadcast to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Per-cell compare result for both patterns
  typedef struct packed {
    logic ok_a;
    logic ok_b;
  } cell_status_t;

endpackage

[src/lnkm_if.sv]
// Raw byte channel
interface lnkm_char_if;
  logic                        valid;
  logic                        ready;
  logic [lnkm_pkg::CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

// Result channel
interface lnkm_result_if;
  logic valid;
  logic ready;
  logic filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// Register write channel
interface lnkm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lnkm_pkg::CFG_INDEX_W-1:0] index;
  logic [lnkm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/lnkm_cfg_regs.sv]
module lnkm_cfg_regs #(
  parameter int PATTERN_CHARS = lnkm_pkg::PATTERN_CHARS_DEFAULT,
  localparam int TEXT_W = lnkm_pkg::CHAR_W * PATTERN_CHARS,
  localparam int LEN_W  = $clog2(PATTERN_CHARS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  lnkm_cfg_if.sink          cfg,
  output logic [TEXT_W-1:0] text_a,
  output logic [LEN_W-1:0]  len_a,
  output logic [TEXT_W-1:0] text_b,
  output logic [LEN_W-1:0]  len_b
);

  localparam logic [lnkm_pkg::LEN_FIELD_W-1:0] LEN_LIMIT =
    lnkm_pkg::LEN_FIELD_W'(PATTERN_CHARS);

  logic [TEXT_W-1:0]                text_a_q;
  logic [TEXT_W-1:0]                text_b_q;
  logic [lnkm_pkg::LEN_FIELD_W-1:0] len_a_q;
  logic [lnkm_pkg::LEN_FIELD_W-1:0] len_b_q;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Decode and store register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      text_a_q <= lnkm_pkg::PATTERN_A_TEXT_RESET[TEXT_W-1:0];
      len_a_q  <= lnkm_pkg::PATTERN_A_LENGTH_RESET;
      text_b_q <= lnkm_pkg::PATTERN_B_TEXT_RESET[TEXT_W-1:0];
      len_b_q  <= lnkm_pkg::PATTERN_B_LENGTH_RESET;
    end else if (cfg.valid) begin
      unique case (lnkm_pkg::reg_index_t'(cfg.index))
        lnkm_pkg::REG_PATTERN_A_TEXT:   text_a_q <= cfg.data[TEXT_W-1:0];
        lnkm_pkg::REG_PATTERN_A_LENGTH: len_a_q  <= cfg.data[lnkm_pkg::LEN_FIELD_W-1:0];
        lnkm_pkg::REG_PATTERN_B_TEXT:   text_b_q <= cfg.data[TEXT_W-1:0];
        lnkm_pkg::REG_PATTERN_B_LENGTH: len_b_q  <= cfg.data[lnkm_pkg::LEN_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clip lengths to the window size
  assign text_a = text_a_q;
  assign text_b = text_b_q;
  assign len_a  = (len_a_q > LEN_LIMIT) ? LEN_W'(PATTERN_CHARS) : len_a_q[LEN_W-1:0];
  assign len_b  = (len_b_q > LEN_LIMIT) ? LEN_W'(PATTERN_CHARS) : len_b_q[LEN_W-1:0];

endmodule

[src/lnkm_cell.sv]
module lnkm_cell #(
  parameter int PATTERN_CHARS = lnkm_pkg::PATTERN_CHARS_DEFAULT,
  parameter int INDEX         = 0,
  localparam int TEXT_W = lnkm_pkg::CHAR_W * PATTERN_CHARS,
  localparam int LEN_W  = $clog2(PATTERN_CHARS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lnkm_pkg::cell_ctrl_t        ctrl,
  input  logic [lnkm_pkg::CHAR_W-1:0] letter_in,
  input  logic                        valid_in,
  input  logic [TEXT_W-1:0]           text_a,
  input  logic [LEN_W-1:0]            len_a,
  input  logic [TEXT_W-1:0]           text_b,
  input  logic [LEN_W-1:0]            len_b,
  output logic [lnkm_pkg::CHAR_W-1:0] letter_q,
  output logic                        valid_q,
  output lnkm_pkg::cell_status_t      status
);

  // Check the letter that enters this cell against the pattern character
  // that lands here; cells past the pattern length always pass.
  function automatic logic lane_ok(
    input logic [TEXT_W-1:0]           text,
    input logic [LEN_W-1:0]            len,
    input logic [lnkm_pkg::CHAR_W-1:0] letter,
    input logic                        valid
  );
    logic                        in_use;
    logic [LEN_W-1:0]            pos;
    logic [lnkm_pkg::CHAR_W-1:0] want;
    in_use = len > LEN_W'(INDEX);
    pos    = len - LEN_W'(INDEX + 1);
    want   = '0;
    for (int b = 0; b < PATTERN_CHARS; b++) begin
      if (pos == LEN_W'(b)) begin
        want = text[lnkm_pkg::CHAR_W*b +: lnkm_pkg::CHAR_W];
      end
    end
    return !in_use || (valid && (letter == want));
  endfunction

  assign status.ok_a = lane_ok(text_a, len_a, letter_in, valid_in);
  assign status.ok_b = lane_ok(text_b, len_b, letter_in, valid_in);

  // Fill flag: drop on clear, follow the neighbor on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      priority if (ctrl.clear) begin
        valid_q <= 1'b0;
      end else if (ctrl.shift) begin
        valid_q <= valid_in;
      end
    end
  end

  // Advance the letter
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      letter_q <= letter_in;
    end
  end

endmodule

[src/letter_normalized_keyword_match_unit.sv]
// A terminator item shows its result in the cycle after it is accepted.
// Throughput: one byte per cycle while no result is stalled; the window shift and both
// pattern compares finish in the cycle the byte is accepted, and one output register holds the result.
// Reset (rst, synchronous, active high) empties the window, clears counts and
// hit flags, drops any pending result and loads the pattern register defaults.
module letter_normalized_keyword_match_unit #(
  parameter int PATTERN_CHARS = lnkm_pkg::PATTERN_CHARS_DEFAULT,
  parameter int MAX_BYTES     = lnkm_pkg::MAX_BYTES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  lnkm_char_if.sink     char_chan,
  lnkm_result_if.source result_chan,
  lnkm_cfg_if.sink      cfg_chan
);

  localparam int TEXT_W  = lnkm_pkg::CHAR_W * PATTERN_CHARS;
  localparam int LEN_W   = $clog2(PATTERN_CHARS + 1);
  localparam int COUNT_W = $clog2(MAX_BYTES + 1);

  localparam logic [lnkm_pkg::CHAR_W-1:0] CHAR_TERMINATOR = 8'h00;
  localparam logic [lnkm_pkg::CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [lnkm_pkg::CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [lnkm_pkg::CHAR_W-1:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [lnkm_pkg::CHAR_W-1:0] CHAR_LOWER_Z    = 8'h7A;
  localparam logic [lnkm_pkg::CHAR_W-1:0] CASE_FOLD       = 8'h20;

  logic [TEXT_W-1:0] text_a;
  logic [TEXT_W-1:0] text_b;
  logic [LEN_W-1:0]  len_a;
  logic [LEN_W-1:0]  len_b;

  logic                        in_accept;
  logic                        term_accept;
  logic                        is_lower;
  logic                        is_upper;
  logic                        keep;
  logic [lnkm_pkg::CHAR_W-1:0] letter;
  lnkm_pkg::cell_ctrl_t        cell_ctrl;

  logic [lnkm_pkg::CHAR_W-1:0] letter_chain [PATTERN_CHARS+1];
  logic                        valid_chain  [PATTERN_CHARS+1];
  lnkm_pkg::cell_status_t      cell_status  [PATTERN_CHARS];
  logic [PATTERN_CHARS-1:0]    ok_a;
  logic [PATTERN_CHARS-1:0]    ok_b;
  logic                        hit_a_now;
  logic                        hit_b_now;

  logic [COUNT_W-1:0] byte_count;
  logic               hit_a;
  logic               hit_b;
  logic               res_valid;
  logic               res_filtered;

  // Pattern registers
  lnkm_cfg_regs #(.PATTERN_CHARS(PATTERN_CHARS)) u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_chan),
    .text_a (text_a),
    .len_a  (len_a),
    .text_b (text_b),
    .len_b  (len_b)
  );

  // Take a new item whenever the output register is free or being emptied
  assign char_chan.ready = !res_valid || result_chan.ready;
  assign in_accept       = char_chan.valid && char_chan.ready;
  assign term_accept     = in_accept && (char_chan.char_in == CHAR_TERMINATOR);

  // Fold letters to lower case, drop everything else
  assign is_lower = (char_chan.char_in >= CHAR_LOWER_A) && (char_chan.char_in <= CHAR_LOWER_Z);
  assign is_upper = (char_chan.char_in >= CHAR_UPPER_A) && (char_chan.char_in <= CHAR_UPPER_Z);
  assign keep     = is_lower || is_upper;
  assign letter   = is_upper ? (char_chan.char_in + CASE_FOLD) : char_chan.char_in;

  assign cell_ctrl.shift = in_accept && keep;
  assign cell_ctrl.clear = term_accept;

  // Window of letters, newest in cell 0
  assign letter_chain[0] = letter;
  assign valid_chain[0]  = 1'b1;

  for (genvar j = 0; j < PATTERN_CHARS; j++) begin : g_cell
    lnkm_cell #(.PATTERN_CHARS(PATTERN_CHARS), .INDEX(j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .letter_in (letter_chain[j]),
      .valid_in  (valid_chain[j]),
      .text_a    (text_a),
      .len_a     (len_a),
      .text_b    (text_b),
      .len_b     (len_b),
      .letter_q  (letter_chain[j+1]),
      .valid_q   (valid_chain[j+1]),
      .status    (cell_status[j])
    );
    assign ok_a[j] = cell_status[j].ok_a;
    assign ok_b[j] = cell_status[j].ok_b;
  end

  // A pattern hits when enabled and every cell it covers agrees
  assign hit_a_now = (len_a != '0) && (&ok_a);
  assign hit_b_now = (len_b != '0) && (&ok_b);

  // String state: saturating byte count and sticky hit flags
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      hit_a      <= 1'b0;
      hit_b      <= 1'b0;
    end else if (term_accept) begin
      byte_count <= '0;
      hit_a      <= 1'b0;
      hit_b      <= 1'b0;
    end else if (in_accept) begin
      if (byte_count < COUNT_W'(MAX_BYTES)) begin
        byte_count <= byte_count + COUNT_W'(1);
      end
      if (cell_ctrl.shift && hit_a_now) begin
        hit_a <= 1'b1;
      end
      if (cell_ctrl.shift && hit_b_now) begin
        hit_b <= 1'b1;
      end
    end
  end

  // Output register: load on terminator, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (term_accept) begin
      res_valid <= 1'b1;
    end else if (result_chan.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_accept) begin
      res_filtered <= (hit_a || hit_b) && (byte_count < COUNT_W'(MAX_BYTES));
    end
  end

  assign result_chan.valid    = res_valid;
  assign result_chan.filtered = res_filtered;

  // Checks
  a_result_follows_term: assert property (@(posedge clk) disable iff (rst)
    term_accept |=> res_valid)
    else $error("terminator did not load a result");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    term_accept |=> (!valid_chain[1] && !hit_a && !hit_b && (byte_count == '0)))
    else $error("string state not cleared after terminator");

  a_window_fills: assert property (@(posedge clk) disable iff (rst)
    cell_ctrl.shift |=> valid_chain[1])
    else $error("newest cell not filled after a kept letter");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(MAX_BYTES))
    else $error("byte count passed its limit");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result_chan.ready) |-> !char_chan.ready)
    else $error("input taken while result stalled");

endmodule

[tb/letter_normalized_keyword_match_unit_tb.sv]
`timescale 1ns / 100ps

module letter_normalized_keyword_match_unit_tb;

  localparam int WINDOW       = lnkm_pkg::PATTERN_CHARS_DEFAULT;
  localparam int BYTE_LIMIT   = lnkm_pkg::MAX_BYTES_DEFAULT;
  localparam int RANDOM_ITEMS = 1600;

  localparam logic [7:0] TERMINATOR = 8'h00;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  logic clk;
  logic rst;

  lnkm_char_if   char_bus();
  lnkm_result_if result_bus();
  lnkm_cfg_if    cfg_bus();

  letter_normalized_keyword_match_unit dut (
    .clk         (clk),
    .rst         (rst),
    .char_chan   (char_bus),
    .result_chan (result_bus),
    .cfg_chan    (cfg_bus)
  );

  // Pattern registers as the block should hold them
  logic [63:0] pat_a_text = lnkm_pkg::PATTERN_A_TEXT_RESET;
  logic [3:0]  pat_a_len  = lnkm_pkg::PATTERN_A_LENGTH_RESET;
  logic [63:0] pat_b_text = lnkm_pkg::PATTERN_B_TEXT_RESET;
  logic [3:0]  pat_b_len  = lnkm_pkg::PATTERN_B_LENGTH_RESET;

  // String state of the match predictor
  logic [7:0] letter_window [WINDOW];
  logic [7:0] string_bytes = '0;
  logic [3:0] letters_kept = '0;
  bit         hit_first    = 0;
  bit         hit_second   = 0;

  logic [7:0] pending_chars [$];
  logic [7:0] string_body [$];
  bit         expected_filtered [$];

  int  char_accepted = 0;
  int  char_issued   = 0;
  int  char_gap      = 0;
  int  result_stall  = 0;
  bit  calm          = 0;

  int  mismatches    = 0;
  int  items_queued  = 0;
  int  strings_sent  = 0;
  int  long_strings  = 0;
  int  results_seen  = 0;
  int  flagged_seen  = 0;
  int  config_writes = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit is_lower(input logic [7:0] b);
    return b >= LOWER_A && b <= LOWER_Z;
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return is_lower(b) || (b >= UPPER_A && b <= UPPER_Z);
  endfunction

  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < WINDOW; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // Clear everything that belongs to one string
  function automatic void clear_string();
    for (int i = 0; i < WINDOW; i++) letter_window[i] = '0;
    string_bytes = '0;
    letters_kept = '0;
    hit_first    = 0;
    hit_second   = 0;
  endfunction

  // True when the pattern ends at the newest kept letter
  function automatic bit ends_here(input logic [63:0] text, input logic [3:0] len_field);
    int n;
    n = (len_field > WINDOW) ? WINDOW : int'(len_field);
    if (n == 0 || letters_kept < n) return 0;
    for (int k = 0; k < n; k++)
      if (letter_window[n-1-k] != text[8*k +: 8]) return 0;
    return 1;
  endfunction

  // Advance the predictor by one accepted byte
  function automatic void take_char(input logic [7:0] c);
    logic [7:0] letter;
    bit         keep;
    if (c == TERMINATOR) begin
      expected_filtered.push_back((hit_first || hit_second) && string_bytes < BYTE_LIMIT);
      clear_string();
      return;
    end
    if (string_bytes < BYTE_LIMIT) string_bytes = string_bytes + 8'd1;
    keep   = is_letter(c);
    letter = is_lower(c) ? c : c + CASE_BIT;
    if (keep) begin
      for (int i = WINDOW - 1; i > 0; i--) letter_window[i] = letter_window[i-1];
      letter_window[0] = letter;
      if (letters_kept < WINDOW) letters_kept = letters_kept + 4'd1;
      if (ends_here(pat_a_text, pat_a_len)) hit_first = 1;
      if (ends_here(pat_b_text, pat_b_len)) hit_second = 1;
    end
  endfunction

  // Byte driver: hold an item until taken, then pick the next one or idle
  always @(negedge clk) begin : char_driver
    logic       nv;
    logic [7:0] nd;
    nv = char_bus.valid;
    nd = char_bus.char_in;
    if (rst) begin
      nv = 1'b0;
      nd = '0;
    end else if (!char_bus.valid || char_accepted == char_issued) begin
      if (char_gap > 0) begin
        nv = 1'b0;
        char_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        nv = 1'b0;
        char_gap = $urandom_range(1, 17) - 1;
      end else if (pending_chars.size() > 0) begin
        nv = 1'b1;
        nd = pending_chars.pop_front();
        char_issued++;
      end else begin
        nv = 1'b0;
      end
    end
    char_bus.valid   <= nv;
    char_bus.char_in <= nd;
  end

  // Count accepted bytes and feed them to the predictor
  always @(posedge clk) begin
    if (!rst && char_bus.valid && char_bus.ready) begin
      char_accepted++;
      take_char(char_bus.char_in);
    end
  end

  // Result ready with random stall bursts
  always @(negedge clk) begin : result_sink
    logic nr;
    if (rst) begin
      nr = 1'b0;
    end else if (result_stall > 0) begin
      nr = 1'b0;
      result_stall--;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      nr = 1'b0;
      result_stall = $urandom_range(1, 17) - 1;
    end else begin
      nr = 1'b1;
    end
    result_bus.ready <= nr;
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : result_monitor
    bit want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (result_bus.filtered === 1'b1) flagged_seen++;
      if (expected_filtered.size() == 0) begin
        report_mismatch($sformatf("result filtered=%b with no terminator pending",
                                  result_bus.filtered));
      end else begin
        want = expected_filtered.pop_front();
        if (result_bus.filtered !== want)
          report_mismatch($sformatf("filtered=%b, expected %b (result %0d)",
                                    result_bus.filtered, want, results_seen));
      end
    end
  end

  task automatic write_register(input lnkm_pkg::reg_index_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      lnkm_pkg::REG_PATTERN_A_TEXT:   pat_a_text = value;
      lnkm_pkg::REG_PATTERN_A_LENGTH: pat_a_len  = value[3:0];
      lnkm_pkg::REG_PATTERN_B_TEXT:   pat_b_text = value;
      lnkm_pkg::REG_PATTERN_B_LENGTH: pat_b_len  = value[3:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait until every byte is taken and every result is back
  task automatic wait_idle();
    int spin;
    spin = 0;
    while ((pending_chars.size() > 0 || char_accepted != char_issued ||
            expected_filtered.size() > 0) && spin < 50000) begin
      @(posedge clk);
      spin++;
    end
    if (pending_chars.size() > 0 || char_accepted != char_issued)
      report_mismatch("byte input stopped taking items");
    if (expected_filtered.size() > 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_filtered.size()));
      expected_filtered.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic push_char(input logic [7:0] b);
    pending_chars.push_back(b);
    items_queued++;
  endtask

  task automatic push_terminator();
    push_char(TERMINATOR);
    strings_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
    push_terminator();
  endtask

  function automatic logic [7:0] random_case(input logic [7:0] b);
    if (is_lower(b) && $urandom_range(0, 1)) return b - CASE_BIT;
    return b;
  endfunction

  function automatic logic [7:0] random_nonletter();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (is_letter(b));
    return b;
  endfunction

  function automatic logic [7:0] random_letter();
    return LOWER_A + 8'($urandom_range(0, 25));
  endfunction

  // Append one occurrence of a pattern, optionally with a letter dropped or changed
  task automatic add_pattern(input logic [63:0] text, input logic [3:0] len_field,
                             input bit broken);
    int         n;
    int         bad;
    logic [7:0] b;
    n   = (len_field > WINDOW) ? WINDOW : int'(len_field);
    bad = -1;
    if (n > 0 && broken) bad = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      b = text[8*k +: 8];
      if (k == bad) begin
        if ($urandom_range(0, 1)) continue;
        b = random_letter();
      end
      if (b != TERMINATOR) string_body.push_back(random_case(b));
      if ($urandom_range(0, 5) == 0) string_body.push_back(random_nonletter());
    end
  endtask

  // Build a string of exactly len bytes around pattern pieces and noise
  task automatic push_string(input int len, input bit lead, input bit terminate);
    int         r;
    logic [7:0] b;
    string_body.delete();
    if (lead) add_pattern(pat_a_text, pat_a_len, 0);
    while (string_body.size() < len) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        add_pattern(pat_a_text, pat_a_len, $urandom_range(0, 3) == 0);
      end else if (r < 5) begin
        add_pattern(pat_b_text, pat_b_len, $urandom_range(0, 3) == 0);
      end else if (r < 8) begin
        b = $urandom_range(0, 1) ? pat_a_text[8*$urandom_range(0, 7) +: 8]
                                 : pat_b_text[8*$urandom_range(0, 7) +: 8];
        if (!is_lower(b)) b = random_letter();
        string_body.push_back(random_case(b));
      end else begin
        string_body.push_back(8'($urandom_range(1, 255)));
      end
    end
    while (string_body.size() > len) void'(string_body.pop_back());
    foreach (string_body[i]) push_char(string_body[i]);
    if (len >= BYTE_LIMIT) long_strings++;
    if (terminate) push_terminator();
  endtask

  // Load one set of pattern registers; the first few are fixed corner settings
  task automatic apply_setting(input int phase);
    logic [63:0] at;
    logic [63:0] bt;
    logic [3:0]  al;
    logic [3:0]  bl;
    int          r;
    case (phase)
      0: begin
        at = pack_text("gameim");   al = 4'd6;
        bt = pack_text("keywords"); bl = 4'd8;
      end
      1: begin
        at = '1;                    al = 4'd8;
        bt = pack_text("ab");       bl = 4'd2;
      end
      2: begin
        at = pack_text("aab") | ({$urandom, $urandom} << 24); al = 4'd3;
        bt = pack_text("abababab"); bl = 4'd15;
      end
      3: begin
        at = pack_text("q");        al = 4'd1;
        bt = '0;                    bl = 4'd0;
      end
      4: begin
        at = pack_text("zzzzzzzz"); al = 4'd0;
        bt = '0;                    bl = 4'd3;
      end
      5: begin
        at = pack_text("gAme");     al = 4'd4;
        bt = pack_text("me") | ({$urandom, $urandom} << 16); bl = 4'd2;
      end
      default: begin
        for (int k = 0; k < WINDOW; k++) begin
          at[8*k +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                      : LOWER_A + 8'($urandom_range(0, 5));
          bt[8*k +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                      : LOWER_A + 8'($urandom_range(0, 5));
        end
        r  = $urandom_range(0, 9);
        al = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
        r  = $urandom_range(0, 9);
        bl = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
      end
    endcase
    write_register(lnkm_pkg::REG_PATTERN_A_TEXT, at);
    write_register(lnkm_pkg::REG_PATTERN_A_LENGTH, {60'd0, al});
    write_register(lnkm_pkg::REG_PATTERN_B_TEXT, bt);
    write_register(lnkm_pkg::REG_PATTERN_B_LENGTH, {60'd0, bl});
  endtask

  initial begin : main_sequence
    int phase;
    int base;
    int target;
    int len;
    int r;
    bit cut;

    rst               = 1'b1;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = lnkm_pkg::REG_PATTERN_A_TEXT;
    cfg_bus.data      = '0;
    clear_string();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings against the reset patterns
    push_text("gAmE@iM");
    push_terminator();
    push_text("GameI");
    push_char(8'hFF); push_char(8'h80); push_char(8'h01); push_char(8'h40);
    push_char(8'h5B); push_char(8'h60); push_char(8'h7B);
    push_char(LOWER_A); push_char(LOWER_Z); push_char(UPPER_A); push_char(UPPER_Z);
    push_terminator();

    // Random phases, each under its own pattern setting
    phase = 0;
    base  = items_queued;
    while (items_queued - base < RANDOM_ITEMS) begin
      wait_idle();
      apply_setting(phase);
      calm   = (items_queued - base) >= RANDOM_ITEMS * 4 / 5;
      target = items_queued + $urandom_range(60, 140);
      if (phase == 0) begin
        // strings just under and at the byte limit, both led by a match
        push_string(BYTE_LIMIT - 1, 1, 1);
        push_string(BYTE_LIMIT, 1, 1);
      end
      while (items_queued < target) begin
        r = $urandom_range(0, 79);
        if (r == 0)     len = $urandom_range(250, 262);
        else if (r < 8) len = $urandom_range(9, 40);
        else            len = $urandom_range(0, 12);
        // leave some phases mid-string so the next setting lands inside a string
        cut = (items_queued + len + 1 >= target) && $urandom_range(0, 2) == 0;
        push_string(len, $urandom_range(0, 3) == 0, !cut);
      end
      phase++;
    end
    push_terminator();
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Ran %0d strings in %0d bytes (%0d at or over the length limit) over %0d settings",
             strings_sent, items_queued, long_strings, phase);
    $display("Checked %0d results, %0d flagged, %0d register writes, %0d mismatches",
             results_seen, flagged_seen, config_writes, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
